>>> rtl/ccwe_pkg.sv
// ----------------------------------------------------------------------------
// ccwe_pkg: shared types and constants of the coulomb counter
// Widths of the serial arithmetic units, charge units, register reset
// values, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package ccwe_pkg;

  // Serial multiplier: multiplicand, multiplier and product widths.
  localparam int unsigned MUL_A_W = 30;
  localparam int unsigned MUL_B_W = 24;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Serial divider by the efficiency unit: dividend and remainder widths.
  localparam int unsigned DIV_W = 49;
  localparam int unsigned REM_W = 14;

  // Magnitude of one scaled charge step, and the charge and sum widths.
  localparam int unsigned DMAG_W   = 37;
  localparam int unsigned CHARGE_W = 47;
  localparam int unsigned SUM_W    = CHARGE_W + 1;

  localparam int unsigned CFG_W = 36;

  // One mAh in mA*ms, and 100 percent in hundredths of a percent.
  localparam logic [21:0] MAMS_PER_MAH = 22'd3600000;
  localparam logic [13:0] EFF_ONE      = 14'd10000;

  localparam logic [23:0] CAPACITY_RST      = 24'd100000;
  localparam logic [13:0] EFF_RST           = 14'd10000;
  localparam logic [35:0] PERSIST_DELTA_RST = 36'd36000000;

  typedef enum logic [1:0] {
    CFG_CAPACITY      = 2'd0,
    CFG_CHARGE_EFF    = 2'd1,
    CFG_DISCHARGE_EFF = 2'd2,
    CFG_PERSIST_DELTA = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EFF,
    S_MAG,
    S_DIV,
    S_LOADW,
    S_LIMIT,
    S_DIFF,
    S_ABS,
    S_CMP,
    S_DONE
  } state_t;

endpackage

>>> rtl/coulomb_counter_with_efficiency.sv
// ----------------------------------------------------------------------------
// coulomb_counter_with_efficiency: battery charge counter
// Integrates current over time with charge/discharge efficiency, clamps the
// charge to the capacity (saturates it if none) and raises persist requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one beat is either an integrate tick
//   (func = 0: current_ma, elapsed_ms) or a load (func = 1: load_mah).
//   Output channel (out_valid/out_ready): exactly one beat per input beat,
//   carrying the charge in mA*ms and the persist request.
//   Configuration: cfg_we writes cfg_data into register cfg_index at once.
//   Sequence: an integrate beat multiplies elapsed_ms by the efficiency and
//   then by the current magnitude in the bit-serial multiplier (one
//   multiplier bit per cycle, 14 then 20 bits), then runs the bit-serial
//   divide by 10000; a load needs one 24-bit serial multiply.
//   One beat is worked on at a time, and the next beat is accepted only
//   once the block is back in idle.
//   The next beat is accepted while a finished result still waits in the
//   output register; if the receiver stalls, the block holds its second
//   result in its last state until the output register is free.
//   Reset sets the charge and the last saved charge to zero and the
//   registers to their defaults; no result is pending after reset.
// ----------------------------------------------------------------------------
module coulomb_counter_with_efficiency (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [ccwe_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic signed [19:0]            current_ma,
  input  logic [15:0]                   elapsed_ms,
  input  logic [23:0]                   load_mah,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [46:0]            charge_mams,
  output logic                          persist_request
);

  localparam int unsigned AW = ccwe_pkg::MUL_A_W;
  localparam int unsigned BW = ccwe_pkg::MUL_B_W;
  localparam int unsigned PW = ccwe_pkg::MUL_P_W;
  localparam int unsigned DW = ccwe_pkg::DIV_W;
  localparam int unsigned MW = ccwe_pkg::DMAG_W;
  localparam int unsigned CW = ccwe_pkg::CHARGE_W;
  localparam int unsigned SW = ccwe_pkg::SUM_W;

  ccwe_pkg::state_t state, state_next;

  logic [23:0] cap_mah;
  logic [13:0] charge_eff;
  logic [13:0] discharge_eff;
  logic [ccwe_pkg::CFG_W-1:0] persist_delta;

  logic        func_r;
  logic        neg_r;
  logic [19:0] mag_r;
  logic        req_r;

  logic signed [CW-1:0] charge_acc;
  logic signed [CW-1:0] saved_charge;
  logic signed [SW-1:0] sum;
  logic [SW-1:0]        diff;
  logic [SW-1:0]        adiff;

  logic [19:0] cur_u;
  logic        neg_in;
  logic [19:0] mag_in;
  logic [13:0] eff_in;

  logic          a_start, a_busy;
  logic [AW-1:0] a_mcand;
  logic [BW-1:0] a_mplr;
  logic [PW-1:0] a_prod;
  logic          b_start, b_busy;
  logic [PW-1:0] b_prod;
  logic          div_start, div_busy;
  logic [DW-1:0] quot;

  logic [SW-1:0]        acc_ext;
  logic [SW-1:0]        saved_ext;
  logic [SW-1:0]        dmag;
  logic signed [SW-1:0] cap_mams;
  logic signed [SW-1:0] lim;

  // Sign and magnitude of the incoming current; zero counts as discharge.
  assign cur_u  = $unsigned(current_ma);
  assign neg_in = cur_u[19];
  assign mag_in = neg_in ? (~cur_u + 20'd1) : cur_u;
  assign eff_in = (!neg_in && (cur_u != '0)) ? charge_eff : discharge_eff;

  assign acc_ext   = {charge_acc[CW-1], charge_acc};
  assign saved_ext = {saved_charge[CW-1], saved_charge};
  assign dmag      = SW'(quot[MW-1:0]);
  assign cap_mams  = $signed({2'b00, b_prod[SW-3:0]});

  ccwe_mul u_mul_a (
    .clk      (clk),
    .rst      (rst),
    .start    (a_start),
    .mcand_in (a_mcand),
    .mplr_in  (a_mplr),
    .busy     (a_busy),
    .product  (a_prod)
  );

  // Capacity in mA*ms, worked out again for every beat.
  ccwe_mul u_mul_cap (
    .clk      (clk),
    .rst      (rst),
    .start    (b_start),
    .mcand_in (AW'(ccwe_pkg::MAMS_PER_MAH)),
    .mplr_in  (cap_mah),
    .busy     (b_busy),
    .product  (b_prod)
  );

  ccwe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (a_prod[DW-1:0]),
    .busy     (div_busy),
    .quotient (quot)
  );

  // Clamp to the capacity, or saturate at the charge range without one.
  always_comb begin
    if (cap_mah != '0) begin
      if (sum[SW-1]) begin
        lim = '0;
      end else if (sum > cap_mams) begin
        lim = cap_mams;
      end else begin
        lim = sum;
      end
    end else if (sum[SW-1] && !sum[SW-2]) begin
      lim = $signed({2'b11, {(SW-2){1'b0}}});
    end else if (!sum[SW-1] && sum[SW-2]) begin
      lim = $signed({2'b00, {(SW-2){1'b1}}});
    end else begin
      lim = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccwe_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    a_start    = 1'b0;
    a_mcand    = '0;
    a_mplr     = '0;
    b_start    = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ccwe_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          a_start = 1'b1;
          b_start = 1'b1;
          if (func) begin
            a_mcand    = AW'(ccwe_pkg::MAMS_PER_MAH);
            a_mplr     = load_mah;
            state_next = ccwe_pkg::S_LOADW;
          end else begin
            a_mcand    = AW'(elapsed_ms);
            a_mplr     = BW'(eff_in);
            state_next = ccwe_pkg::S_EFF;
          end
        end
      end
      ccwe_pkg::S_EFF: begin
        if (!a_busy) begin
          a_start    = 1'b1;
          a_mcand    = a_prod[AW-1:0];
          a_mplr     = BW'(mag_r);
          state_next = ccwe_pkg::S_MAG;
        end
      end
      ccwe_pkg::S_MAG: begin
        if (!a_busy) begin
          div_start  = 1'b1;
          state_next = ccwe_pkg::S_DIV;
        end
      end
      ccwe_pkg::S_DIV: begin
        if (!div_busy) begin
          state_next = ccwe_pkg::S_LIMIT;
        end
      end
      ccwe_pkg::S_LOADW: begin
        if (!a_busy) begin
          state_next = ccwe_pkg::S_LIMIT;
        end
      end
      ccwe_pkg::S_LIMIT: begin
        if (!b_busy) begin
          state_next = func_r ? ccwe_pkg::S_DONE : ccwe_pkg::S_DIFF;
        end
      end
      ccwe_pkg::S_DIFF: state_next = ccwe_pkg::S_ABS;
      ccwe_pkg::S_ABS:  state_next = ccwe_pkg::S_CMP;
      ccwe_pkg::S_CMP:  state_next = ccwe_pkg::S_DONE;
      ccwe_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ccwe_pkg::S_IDLE;
        end
      end
      default: state_next = ccwe_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_mah       <= ccwe_pkg::CAPACITY_RST;
      charge_eff    <= ccwe_pkg::EFF_RST;
      discharge_eff <= ccwe_pkg::EFF_RST;
      persist_delta <= ccwe_pkg::PERSIST_DELTA_RST;
      charge_acc    <= '0;
      saved_charge  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ccwe_pkg::CFG_CAPACITY:      cap_mah       <= cfg_data[23:0];
          ccwe_pkg::CFG_CHARGE_EFF:    charge_eff    <= cfg_data[13:0];
          ccwe_pkg::CFG_DISCHARGE_EFF: discharge_eff <= cfg_data[13:0];
          ccwe_pkg::CFG_PERSIST_DELTA: persist_delta <= cfg_data;
          default: ;
        endcase
      end

      // A finished result loads the output register once it is free.
      if ((state == ccwe_pkg::S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ccwe_pkg::S_IDLE: begin
          if (in_valid) begin
            func_r <= func;
            neg_r  <= neg_in;
            mag_r  <= mag_in;
          end
        end
        ccwe_pkg::S_DIV: begin
          if (!div_busy) begin
            sum <= $signed(neg_r ? (acc_ext - dmag) : (acc_ext + dmag));
          end
        end
        ccwe_pkg::S_LOADW: begin
          if (!a_busy) begin
            sum <= $signed(SW'(a_prod[SW-3:0]));
          end
        end
        ccwe_pkg::S_LIMIT: begin
          if (!b_busy) begin
            charge_acc <= $signed(lim[CW-1:0]);
            if (func_r) begin
              saved_charge <= $signed(lim[CW-1:0]);
              req_r        <= 1'b1;
            end
          end
        end
        ccwe_pkg::S_DIFF: diff <= acc_ext - saved_ext;
        ccwe_pkg::S_ABS:  adiff <= diff[SW-1] ? (~diff + 1'b1) : diff;
        ccwe_pkg::S_CMP: begin
          req_r <= (adiff >= SW'(persist_delta));
          if (adiff >= SW'(persist_delta)) begin
            saved_charge <= charge_acc;
          end
        end
        ccwe_pkg::S_DONE: begin
          if (!out_valid || out_ready) begin
            charge_mams     <= charge_acc;
            persist_request <= req_r;
          end
        end
        default: ;
      endcase
    end
  end

  a_clamp_floor: assert property (@(posedge clk) disable iff (rst)
    ((state == ccwe_pkg::S_LIMIT) && !b_busy && (cap_mah != '0))
      |=> !charge_acc[CW-1])
    else $error("clamped charge went below zero");

  a_load_persists: assert property (@(posedge clk) disable iff (rst)
    ((state == ccwe_pkg::S_LIMIT) && !b_busy && func_r)
      |=> (req_r && (saved_charge == charge_acc)))
    else $error("load beat did not record a persist");

  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ccwe_pkg::S_DONE) |-> (!a_busy && !b_busy && !div_busy))
    else $error("arithmetic unit still running at result time");

endmodule

>>> rtl/ccwe_mul.sv
// ----------------------------------------------------------------------------
// ccwe_mul: bit-serial shift-and-add multiplier
// Takes one multiplier bit per cycle, LSB first, and stops as soon as the
// remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
module ccwe_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ccwe_pkg::MUL_A_W-1:0]  mcand_in,
  input  logic [ccwe_pkg::MUL_B_W-1:0]  mplr_in,
  output logic                          busy,
  output logic [ccwe_pkg::MUL_P_W-1:0]  product
);

  localparam int unsigned BW = ccwe_pkg::MUL_B_W;
  localparam int unsigned PW = ccwe_pkg::MUL_P_W;

  logic [PW-1:0] mcand;
  logic [BW-1:0] mplr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && (mplr[BW-1:1] == '0)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      product <= '0;
    end else if (start) begin
      mcand   <= PW'(mcand_in);
      mplr    <= mplr_in;
      product <= '0;
    end else if (busy) begin
      if (mplr[0]) begin
        product <= product + mcand;
      end
      mcand <= mcand << 1;
      mplr  <= mplr >> 1;
    end
  end

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    start |=> (busy && (product == '0)))
    else $error("multiplier did not start from a cleared product");

  a_serial_shift: assert property (@(posedge clk) disable iff (rst)
    (busy && !start) |=> (mplr == ($past(mplr) >> 1)))
    else $error("multiplier consumed other than one bit per cycle");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> $stable(product))
    else $error("product changed while the multiplier was idle");

endmodule

>>> rtl/ccwe_div.sv
// ----------------------------------------------------------------------------
// ccwe_div: bit-serial restoring divider by the efficiency unit
// Produces one quotient bit per cycle, MSB first; the quotient replaces the
// dividend in the same shift register.
// ----------------------------------------------------------------------------
module ccwe_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ccwe_pkg::DIV_W-1:0]  dividend,
  output logic                        busy,
  output logic [ccwe_pkg::DIV_W-1:0]  quotient
);

  localparam int unsigned DW    = ccwe_pkg::DIV_W;
  localparam int unsigned RW    = ccwe_pkg::REM_W;
  localparam int unsigned CNT_W = $clog2(DW);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DW - 1);

  logic [DW-1:0]    work;
  logic [RW-1:0]    rem;
  logic [CNT_W-1:0] cnt;
  logic [RW:0]      trial;
  logic             fits;

  assign trial    = {rem, work[DW-1]};
  assign fits     = (trial >= {1'b0, ccwe_pkg::EFF_ONE});
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == LAST) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
    end else if (busy) begin
      rem  <= fits ? RW'(trial - {1'b0, ccwe_pkg::EFF_ONE}) : trial[RW-1:0];
      work <= {work[DW-2:0], fits};
    end
  end

  a_start_count: assert property (@(posedge clk) disable iff (rst)
    start |=> (busy && (cnt == '0)))
    else $error("divider did not restart its bit count");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem < ccwe_pkg::EFF_ONE))
    else $error("divider remainder out of range");

  a_finish: assert property (@(posedge clk) disable iff (rst)
    (busy && !start && (cnt == LAST)) |=> !busy)
    else $error("divider ran past its last quotient bit");

endmodule

>>> tb/sv/coulomb_counter_with_efficiency_test.sv
// ----------------------------------------------------------------------------
// coulomb_counter_with_efficiency_test: self-checking bench of the charge counter
// Sends integrate and load beats with random idling on both channels, keeps
// its own copy of the charge and the last saved charge, and compares every
// result beat with the prediction. Register settings cover the capacity clamp,
// saturation without a capacity, efficiencies above one and persist
// thresholds from zero up to the largest value.
// ----------------------------------------------------------------------------
localparam longint CHARGE_RAIL_HI = 64'sd70368744177663;
localparam longint CHARGE_RAIL_LO = -64'sd70368744177664;

typedef struct packed {
  logic signed [46:0] charge;
  logic               persist;
} charge_beat_t;

typedef enum {MIX, CHARGE_RAIL, DISCHARGE_RAIL} stim_mode_t;

class charge_tracker;
  logic [23:0] capacity;
  logic [13:0] chg_eff;
  logic [13:0] dis_eff;
  logic [35:0] persist_delta;
  longint charge;
  longint saved;
  charge_beat_t expected_q[$];
  int unsigned errors, checked, loads, persists, at_limit;

  function new();
    capacity = ccwe_pkg::CAPACITY_RST;
    chg_eff = ccwe_pkg::EFF_RST;
    dis_eff = ccwe_pkg::EFF_RST;
    persist_delta = ccwe_pkg::PERSIST_DELTA_RST;
    charge = 0;
    saved = 0;
    errors = 0;
    checked = 0;
    loads = 0;
    persists = 0;
    at_limit = 0;
  endfunction

  function void set_reg(ccwe_pkg::cfg_idx_t idx, logic [35:0] value);
    case (idx)
      ccwe_pkg::CFG_CAPACITY:      capacity = value[23:0];
      ccwe_pkg::CFG_CHARGE_EFF:    chg_eff = value[13:0];
      ccwe_pkg::CFG_DISCHARGE_EFF: dis_eff = value[13:0];
      ccwe_pkg::CFG_PERSIST_DELTA: persist_delta = value;
    endcase
  endfunction

  // Clamp to the capacity when one is set, otherwise saturate at the rails.
  function longint limit_charge(longint v);
    longint lo, hi;
    if (capacity != 0) begin
      lo = 0;
      hi = longint'(capacity) * longint'(ccwe_pkg::MAMS_PER_MAH);
    end else begin
      lo = CHARGE_RAIL_LO;
      hi = CHARGE_RAIL_HI;
    end
    if (v < lo || v > hi) at_limit++;
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function void note_beat(logic f, logic signed [19:0] cur, logic [15:0] el,
                          logic [23:0] ld);
    longint amps, step, drift;
    logic [13:0] eff;
    logic persist;
    charge_beat_t beat;
    if (f) begin
      charge = limit_charge(longint'(ld) * longint'(ccwe_pkg::MAMS_PER_MAH));
      saved = charge;
      persist = 1'b1;
      loads++;
    end else begin
      amps = longint'(cur);
      eff = (amps > 0) ? chg_eff : dis_eff;
      // Scale the magnitude so that truncation goes toward zero.
      step = ((amps < 0 ? -amps : amps) * longint'(el) * longint'(eff)) /
             longint'(ccwe_pkg::EFF_ONE);
      if (amps < 0) step = -step;
      charge = limit_charge(charge + step);
      drift = charge - saved;
      if (drift < 0) drift = -drift;
      persist = (drift >= longint'(persist_delta));
      if (persist) saved = charge;
    end
    beat.charge = charge[46:0];
    beat.persist = persist;
    expected_q.push_back(beat);
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 40) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task check_beat(logic signed [46:0] got_charge, logic got_persist);
    charge_beat_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("result beat with nothing expected, charge %0d", got_charge));
    end else begin
      want = expected_q.pop_front();
      checked++;
      if (want.persist) persists++;
      if (got_charge !== want.charge)
        report($sformatf("charge %0d, expected %0d", got_charge, want.charge));
      if (got_persist !== want.persist)
        report($sformatf("persist request %0b, expected %0b", got_persist,
                         want.persist));
    end
  endtask

  function int pending();
    return expected_q.size();
  endfunction
endclass

module coulomb_counter_with_efficiency_test;
  localparam int STALL_LIMIT = 2000;
  localparam logic signed [19:0] CUR_MAX = 20'sh7FFFF;
  localparam logic signed [19:0] CUR_MIN = 20'sh80000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [35:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               func = 1'b0;
  logic signed [19:0] current_ma = '0;
  logic [15:0]        elapsed_ms = '0;
  logic [23:0]        load_mah = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [46:0] charge_mams;
  logic               persist_request;

  charge_tracker tracker = new;
  bit idle_on = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;
  int settings = 0;

  coulomb_counter_with_efficiency dut (.*);

  always #4 clk = ~clk;

  // Check the result before noting a new input: a beat accepted at this edge
  // cannot have produced the result leaving at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) tracker.check_beat(charge_mams, persist_request);
      if (in_valid && in_ready) tracker.note_beat(func, current_ma, elapsed_ms, load_mah);
      if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready = 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_ready = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("watchdog: %0d cycles without a beat", STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Called right after a falling edge; returns right after the falling edge
  // that follows acceptance, with valid still high.
  task automatic send_beat(logic f, logic signed [19:0] cur, logic [15:0] el,
                           logic [23:0] ld);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    func = f;
    current_ma = cur;
    elapsed_ms = el;
    load_mah = ld;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(ccwe_pkg::cfg_idx_t idx, logic [35:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    tracker.set_reg(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(logic [23:0] cap, logic [13:0] ce, logic [13:0] de,
                           logic [35:0] pd);
    wait_drained();
    write_reg(ccwe_pkg::CFG_CAPACITY, 36'(cap));
    write_reg(ccwe_pkg::CFG_CHARGE_EFF, 36'(ce));
    write_reg(ccwe_pkg::CFG_DISCHARGE_EFF, 36'(de));
    write_reg(ccwe_pkg::CFG_PERSIST_DELTA, pd);
    settings++;
  endtask

  task automatic run_phase(stim_mode_t mode, int unsigned count);
    logic f;
    logic signed [19:0] cur;
    logic [15:0] el;
    logic [23:0] ld;
    for (int unsigned n = 0; n < count; n++) begin
      ld = 24'($urandom);
      if (mode == MIX) begin
        f = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 3))
          0: cur = 20'($urandom);
          1: cur = 20'(int'($urandom_range(0, 2000)) - 1000);
          2: cur = $urandom_range(0, 1) ? CUR_MAX : CUR_MIN;
          default: cur = 20'(int'($urandom_range(0, 60000)) - 30000);
        endcase
        case ($urandom_range(0, 3))
          0: el = 16'($urandom);
          1: el = 16'($urandom_range(10, 200));
          2: el = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
          default: el = 16'($urandom_range(0, 5000));
        endcase
        if ($urandom_range(0, 1))
          ld = 24'($urandom_range(0, tracker.capacity == 0 ? 10000000 : tracker.capacity));
      end else if (n == 0) begin
        // Start the run to a rail from the nearest point a load can reach.
        f = 1'b1;
        cur = 20'($urandom);
        el = 16'($urandom);
        ld = (mode == CHARGE_RAIL) ? 24'hFFFFFF : 24'h0;
      end else begin
        f = 1'b0;
        el = 16'(16'hFFFF - $urandom_range(0, 255));
        if (mode == CHARGE_RAIL) cur = 20'(CUR_MAX - $urandom_range(0, 255));
        else cur = 20'(CUR_MIN + $urandom_range(0, 255));
      end
      send_beat(f, cur, el, ld);
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // Register defaults: large capacity, unit efficiencies.
    send_beat(1'b0, 20'sd0, 16'd0, 24'd0);
    send_beat(1'b0, CUR_MAX, 16'hFFFF, 24'hFFFFFF);
    send_beat(1'b0, CUR_MIN, 16'hFFFF, 24'd0);
    send_beat(1'b0, 20'sd1, 16'd1, 24'd0);
    send_beat(1'b0, -20'sd1, 16'd1, 24'd0);
    send_beat(1'b1, CUR_MIN, 16'hFFFF, 24'hFFFFFF);
    send_beat(1'b0, CUR_MAX, 16'hFFFF, 24'd0);
    send_beat(1'b1, 20'sd0, 16'd0, 24'd100000);
    send_beat(1'b1, CUR_MAX, 16'd0, 24'd0);
    send_beat(1'b0, 20'sd1000, 16'd36, 24'd0);
    // Crosses the persist threshold by 36000 mA*ms.
    send_beat(1'b0, 20'sd1000, 16'd36000, 24'd0);

    // No clamp, gain above one on charge, zero on discharge, persist always.
    configure(24'd0, 14'd16383, 14'd0, 36'd0);
    send_beat(1'b1, 20'sd0, 16'd0, 24'hFFFFFF);
    send_beat(1'b0, CUR_MAX, 16'hFFFF, 24'd0);
    send_beat(1'b0, CUR_MIN, 16'hFFFF, 24'd0);
    send_beat(1'b0, 20'sd0, 16'hFFFF, 24'd0);

    configure(24'd1, 14'd0, 14'd16383, 36'hFFFFFFFFF);
    send_beat(1'b0, CUR_MAX, 16'hFFFF, 24'd0);
    send_beat(1'b1, 20'sd0, 16'd0, 24'd2);
    send_beat(1'b0, CUR_MIN, 16'hFFFF, 24'd0);
    send_beat(1'b0, CUR_MAX, 16'hFFFF, 24'd0);

    configure(24'd10000000, 14'd10000, 14'd10000, 36'hFFFFFFFFF);
    send_beat(1'b1, 20'sd0, 16'd0, 24'd10000000);
    send_beat(1'b1, 20'sd0, 16'd0, 24'hFFFFFF);
    send_beat(1'b0, CUR_MIN, 16'hFFFF, 24'd0);

    configure(24'd100000, 14'd9500, 14'd9000, 36'd36000000);
    run_phase(MIX, 200);
    configure(24'd1, 14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
              36'($urandom_range(0, 10000000)));
    run_phase(MIX, 100);
    configure(24'd10000000, 14'd10000, 14'd10000, 36'd0);
    run_phase(MIX, 100);
    configure(24'd0, 14'd16383, 14'd16383, 36'($urandom_range(0, 2000000000)));
    run_phase(CHARGE_RAIL, 220);
    configure(24'($urandom_range(1, 10000000)), 14'($urandom_range(0, 16383)),
              14'($urandom_range(0, 16383)), 36'($urandom_range(0, 2000000000)));
    run_phase(MIX, 150);

    // The last stretch of strong discharge goes without idling.
    idle_on = 1'b0;
    configure(24'd0, 14'($urandom_range(0, 16383)), 14'd16383,
              36'($urandom_range(0, 2000000000)));
    run_phase(DISCHARGE_RAIL, 260);

    wait_drained();
    repeat (100) @(posedge clk);

    $display("%0d result beats checked over %0d register settings: %0d loads, %0d persists",
             tracker.checked, settings, tracker.loads, tracker.persists);
    $display("%0d results held at the capacity clamp or a rail, %0d mismatches",
             tracker.at_limit, tracker.errors);
    if (tracker.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/ccwe_pkg.sv
rtl/ccwe_mul.sv
rtl/ccwe_div.sv
rtl/coulomb_counter_with_efficiency.sv
tb/sv/coulomb_counter_with_efficiency_test.sv
